// File: hw/rtl/zigzag_varint_delta_decoder_unit_defines.svh
// Assertion macros used by the checker module of the varint delta decoder.
`ifndef ZIGZAG_VARINT_DELTA_DECODER_UNIT_DEFINES_SVH
`define ZIGZAG_VARINT_DELTA_DECODER_UNIT_DEFINES_SVH

// A condition on one clock edge implies another on the same edge.
`define ZVDD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("zvdd assertion failed");

// A condition on one clock edge implies another on the next edge.
`define ZVDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("zvdd assertion failed");

`endif

// File: hw/rtl/zvdd_pkg.sv
// Types and constants of the zigzag varint delta decoder.
package zvdd_pkg;

  localparam int unsigned WordW = 32;
  localparam logic [WordW-1:0] LimitReset = 32'd100000000;
  localparam logic [2:0] MaxGroups = 3'd5;
  localparam logic [2:0] HdrLastByte = 3'd7;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_NODE   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SHORT_HDR = 3'd1,
    ERR_OVER_LIM  = 3'd2,
    ERR_OVERLONG  = 3'd3,
    ERR_SHORT_VAR = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } in_beat_t;

  typedef struct packed {
    kind_e                    kind;
    logic signed [WordW-1:0]  record_id;
    logic [WordW-1:0]         path_length;
    logic signed [WordW-1:0]  node_id;
    logic                     record_done;
    err_e                     error_code;
  } out_beat_t;

endpackage

// File: hw/rtl/zigzag_varint_delta_decoder_unit.sv
// Path record decoder: headers, zigzag varint node deltas, end marks and errors.
//
// The unit takes one byte or an end-of-stream mark per beat and returns at most
// one result per beat. It accepts a beat in every cycle while in_stall_o is low.
// All parsing for a beat is combinational, between the parse state registers
// and the result register. A skid register behind the result register takes one
// further result while the output is stalled; in_stall_o is high exactly while
// that skid register is full, so the input stall comes from a flop. The length
// limit register resets to 100000000 and is written through cfg_we_i and
// cfg_wdata_i; the user must write it only while idle, which the block does not enforce.
module zigzag_varint_delta_decoder_unit
  import zvdd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WordW-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o
);

  logic [WordW-1:0] lim_q;
  logic             in_body_q, in_body_d;
  logic [2:0]       hdr_cnt_q, hdr_cnt_d;
  logic [WordW-1:0] rid_q, rid_d;
  logic [WordW-1:0] len_q, len_d;
  logic [WordW-1:0] remain_q, remain_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [2:0]       grp_q, grp_d;
  logic [WordW-1:0] prev_q, prev_d;

  logic             out_valid_q;
  out_beat_t        out_q;
  logic             skid_valid_q;
  out_beat_t        skid_q;

  logic             in_fire, out_fire;
  logic             res_vld;
  out_beat_t        res;
  logic [7:0]       b;
  logic [WordW-1:0] len_full;
  logic [WordW-1:0] grp_bits;
  logic [WordW-1:0] acc_new;
  logic [WordW-1:0] delta;
  logic [WordW-1:0] node;
  logic             last_node;

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_fire     = in_valid_i & ~skid_valid_q;
  assign out_fire    = out_valid_q & ~out_stall_i;
  assign b           = in_data_i.byte_in;

  assign len_full  = {b, len_q[23:0]};
  assign acc_new   = acc_q | grp_bits;
  assign delta     = {1'b0, acc_new[WordW-1:1]} ^ {WordW{acc_new[0]}};
  assign node      = prev_q + delta;
  assign last_node = (remain_q == WordW'(1));

  always_comb begin
    case (grp_q)
      3'd0:    grp_bits = {25'd0, b[6:0]};
      3'd1:    grp_bits = {18'd0, b[6:0], 7'd0};
      3'd2:    grp_bits = {11'd0, b[6:0], 14'd0};
      3'd3:    grp_bits = {4'd0, b[6:0], 21'd0};
      default: grp_bits = {b[3:0], 28'd0};
    endcase
  end

  always_comb begin
    in_body_d = in_body_q;
    hdr_cnt_d = hdr_cnt_q;
    rid_d     = rid_q;
    len_d     = len_q;
    remain_d  = remain_q;
    acc_d     = acc_q;
    grp_d     = grp_q;
    prev_d    = prev_q;
    res_vld   = 1'b0;
    res       = '0;
    if (in_data_i.end_of_stream) begin
      res_vld   = 1'b1;
      in_body_d = 1'b0;
      hdr_cnt_d = '0;
      grp_d     = '0;
      acc_d     = '0;
      if (in_body_q) begin
        res.kind        = KIND_ERROR;
        res.error_code  = ERR_SHORT_VAR;
        res.record_id   = rid_q;
        res.path_length = len_q;
      end else if (hdr_cnt_q != 3'd0) begin
        res.kind       = KIND_ERROR;
        res.error_code = ERR_SHORT_HDR;
      end else begin
        res.kind = KIND_END;
      end
    end else if (!in_body_q) begin
      case (hdr_cnt_q)
        3'd0:    rid_d[7:0]   = b;
        3'd1:    rid_d[15:8]  = b;
        3'd2:    rid_d[23:16] = b;
        3'd3:    rid_d[31:24] = b;
        3'd4:    len_d[7:0]   = b;
        3'd5:    len_d[15:8]  = b;
        3'd6:    len_d[23:16] = b;
        default: len_d[31:24] = b;
      endcase
      if (hdr_cnt_q != HdrLastByte) begin
        hdr_cnt_d = hdr_cnt_q + 3'd1;
      end else begin
        hdr_cnt_d       = '0;
        res_vld         = 1'b1;
        res.record_id   = rid_q;
        res.path_length = len_full;
        if (len_full > lim_q) begin
          res.kind       = KIND_ERROR;
          res.error_code = ERR_OVER_LIM;
        end else begin
          res.kind        = KIND_HEADER;
          res.record_done = (len_full == '0);
          in_body_d       = (len_full != '0);
          remain_d        = len_full;
          prev_d          = '0;
          acc_d           = '0;
          grp_d           = '0;
        end
      end
    end else if (grp_q >= MaxGroups) begin
      res_vld         = 1'b1;
      res.kind        = KIND_ERROR;
      res.error_code  = ERR_OVERLONG;
      res.record_id   = rid_q;
      res.path_length = len_q;
      in_body_d       = 1'b0;
      grp_d           = '0;
      acc_d           = '0;
    end else if (b[7]) begin
      acc_d = acc_new;
      grp_d = grp_q + 3'd1;
    end else begin
      res_vld         = 1'b1;
      res.kind        = KIND_NODE;
      res.record_id   = rid_q;
      res.path_length = len_q;
      res.node_id     = node;
      res.record_done = last_node;
      prev_d          = node;
      remain_d        = remain_q - WordW'(1);
      acc_d           = '0;
      grp_d           = '0;
      if (last_node) begin
        in_body_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q     <= LimitReset;
      in_body_q <= 1'b0;
      hdr_cnt_q <= '0;
      remain_q  <= '0;
      acc_q     <= '0;
      grp_q     <= '0;
      prev_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        in_body_q <= in_body_d;
        hdr_cnt_q <= hdr_cnt_d;
        remain_q  <= remain_d;
        acc_q     <= acc_d;
        grp_q     <= grp_d;
        prev_q    <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rid_q <= rid_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && res_vld) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_vld) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

endmodule

// File: hw/rtl/zvdd_checker.sv
// Port-level checker for the varint delta decoder and its bind statement.
`include "zigzag_varint_delta_decoder_unit_defines.svh"

module zvdd_checker
  import zvdd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_beat_t        out_data_o
);

  logic out_held;
  logic out_err;
  logic out_ok;
  logic out_end;
  logic no_node;

  assign out_held = out_valid_o && out_stall_i;
  assign out_err  = out_valid_o && (out_data_o.kind == KIND_ERROR);
  assign out_ok   = out_valid_o && (out_data_o.kind != KIND_ERROR);
  assign out_end  = out_valid_o && (out_data_o.kind == KIND_END);
  assign no_node  = (out_data_o.node_id == '0) && !out_data_o.record_done;

  `ZVDD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_data_o))
  `ZVDD_ASSERT_SAME(a_err_code, clk_i, rst_ni, out_ok, out_data_o.error_code == ERR_NONE)
  `ZVDD_ASSERT_SAME(a_err_fields, clk_i, rst_ni, out_err, (out_data_o.error_code != ERR_NONE) && no_node)
  `ZVDD_ASSERT_SAME(a_end_zero, clk_i, rst_ni, out_end, (out_data_o.record_id == '0) && (out_data_o.path_length == '0) && no_node)
  `ZVDD_ASSERT_SAME(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

bind zigzag_varint_delta_decoder_unit zvdd_checker u_zvdd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
